@@ rtl/tkd_pkg.sv @@
// Package for the terminal key escape decoder: key kinds, parse phases,
// byte constants and the two key lookup functions.
// No dependencies; used by terminal_key_escape_decoder.
`default_nettype none

package tkd_pkg;

  typedef logic [3:0] key_kind_t;
  typedef logic [2:0] phase_t;
  typedef logic [7:0] byte_t;
  typedef logic [3:0] digit_t;

  // Key kinds as they appear on the result channel.
  localparam key_kind_t K_PLAIN = 4'd0;
  localparam key_kind_t K_ESC   = 4'd1;
  localparam key_kind_t K_UP    = 4'd2;
  localparam key_kind_t K_DOWN  = 4'd3;
  localparam key_kind_t K_RIGHT = 4'd4;
  localparam key_kind_t K_LEFT  = 4'd5;
  localparam key_kind_t K_HOME  = 4'd6;
  localparam key_kind_t K_END   = 4'd7;
  localparam key_kind_t K_DEL   = 4'd8;
  localparam key_kind_t K_PGUP  = 4'd9;
  localparam key_kind_t K_PGDN  = 4'd10;

  // Parse phases.
  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_ESC   = 3'd1;
  localparam phase_t PH_BRK   = 3'd2;
  localparam phase_t PH_SS3   = 3'd3;
  localparam phase_t PH_OTHER = 3'd4;
  localparam phase_t PH_DIGIT = 3'd5;

  // Bytes of interest.
  localparam byte_t B_ESC     = 8'h1B;
  localparam byte_t B_BRACKET = 8'h5B; // '['
  localparam byte_t B_SS3     = 8'h4F; // 'O'
  localparam byte_t B_TILDE   = 8'h7E; // '~'
  localparam byte_t B_A       = 8'h41;
  localparam byte_t B_B       = 8'h42;
  localparam byte_t B_C       = 8'h43;
  localparam byte_t B_D       = 8'h44;
  localparam byte_t B_H       = 8'h48;
  localparam byte_t B_F       = 8'h46;
  localparam byte_t B_ZERO    = 8'h30;
  localparam byte_t B_NINE    = 8'h39;

  // Final letter of an ESC '[' sequence.
  function automatic key_kind_t bracket_letter(input byte_t b);
    key_kind_t k;
    case (b)
      B_A:     k = K_UP;
      B_B:     k = K_DOWN;
      B_C:     k = K_RIGHT;
      B_D:     k = K_LEFT;
      B_H:     k = K_HOME;
      B_F:     k = K_END;
      default: k = K_ESC;
    endcase
    return k;
  endfunction

  // Key named by the digit of an ESC '[' digit '~' sequence.
  function automatic key_kind_t digit_key(input digit_t d);
    key_kind_t k;
    case (d) inside
      4'd1, 4'd7: k = K_HOME;
      4'd3:       k = K_DEL;
      4'd4, 4'd8: k = K_END;
      4'd5:       k = K_PGUP;
      4'd6:       k = K_PGDN;
      default:    k = K_ESC;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/terminal_key_escape_decoder.sv @@
// Terminal key escape decoder: turns a byte stream with timeout events into
// key requests. Depends on tkd_pkg for key kinds, phases and lookups.
//
// Usage: each input request carries one received byte (in_byte) or a
// timeout event (in_timeout high, in_byte ignored). Plain bytes come out
// as plain keys with their value; escape sequences for the cursor, home,
// end, delete and page keys come out as named keys with a zero byte, and
// a broken or unknown sequence, or a timeout inside one, gives a lone
// escape. Bytes that only advance a sequence, and a timeout while idle,
// give no result request.
// A result appears on the out_ channel in the cycle after the input
// request that completes it is accepted. Throughput: one input request per
// cycle while the result register is not stalled; the parse state and the
// result register are both updated in the accepting cycle.
// Stalls: the result register holds its request until out_ready; while it
// is full and stalled, in_ready is low. It is freed and refilled in the
// same cycle, so no bubble appears when the receiver keeps up.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the
// result register.
`default_nettype none

module terminal_key_escape_decoder (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  tkd_pkg::byte_t     in_byte,
  input  wire                      in_timeout,
  output logic                     out_valid,
  input  wire                      out_ready,
  output tkd_pkg::key_kind_t       out_key_kind,
  output tkd_pkg::byte_t           out_key_byte
);
  import tkd_pkg::*;

  phase_t    phase_r, phase_nxt;
  digit_t    digit_r, digit_nxt;
  logic      out_valid_r, out_valid_nxt;
  key_kind_t kind_r;
  byte_t     byte_r;

  logic      acc;
  logic      emit;
  key_kind_t emit_kind;
  byte_t     emit_byte;
  logic      is_digit;

  assign in_ready     = !out_valid_r || out_ready;
  assign acc          = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_key_kind = kind_r;
  assign out_key_byte = byte_r;
  assign is_digit     = (in_byte >= B_ZERO) && (in_byte <= B_NINE);

  always_comb begin
    emit      = 1'b0;
    emit_kind = K_ESC;
    emit_byte = '0;
    digit_nxt = digit_r;
    phase_nxt = PH_IDLE;
    unique case (phase_r)
      PH_ESC: begin
        if (in_timeout) begin
          emit = 1'b1;
        end else if (in_byte == B_BRACKET) begin
          phase_nxt = PH_BRK;
        end else if (in_byte == B_SS3) begin
          phase_nxt = PH_SS3;
        end else begin
          phase_nxt = PH_OTHER;
        end
      end
      PH_BRK: begin
        if (in_timeout) begin
          emit = 1'b1;
        end else if (is_digit) begin
          digit_nxt = in_byte[3:0];
          phase_nxt = PH_DIGIT;
        end else begin
          emit      = 1'b1;
          emit_kind = bracket_letter(in_byte);
        end
      end
      PH_SS3: begin
        emit = 1'b1;
        if (!in_timeout && in_byte == B_H) begin
          emit_kind = K_HOME;
        end else if (!in_timeout && in_byte == B_F) begin
          emit_kind = K_END;
        end
      end
      PH_DIGIT: begin
        emit = 1'b1;
        if (!in_timeout && in_byte == B_TILDE) begin
          emit_kind = digit_key(digit_r);
        end
      end
      PH_OTHER: begin
        emit = 1'b1;
      end
      default: begin
        // Idle, and the unused codes behave as idle.
        if (!in_timeout) begin
          if (in_byte == B_ESC) begin
            phase_nxt = PH_ESC;
          end else begin
            emit      = 1'b1;
            emit_kind = K_PLAIN;
            emit_byte = in_byte;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      digit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        phase_r <= phase_nxt;
        digit_r <= digit_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      kind_r <= emit_kind;
      byte_r <= emit_byte;
    end
  end

  // Only a plain key carries a byte value.
  a_byte_only_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != K_PLAIN |-> byte_r == '0)
    else $error("non-plain key with nonzero byte");

  // A timeout inside a sequence ends it with a lone escape.
  a_timeout_escape: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_timeout && phase_r != PH_IDLE |=>
      out_valid_r && kind_r == K_ESC && phase_r == PH_IDLE)
    else $error("timeout in sequence did not give escape");

  // ESC while idle starts a sequence and gives no result.
  a_esc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_timeout && in_byte == B_ESC && phase_r == PH_IDLE |=>
      !out_valid_r && phase_r == PH_ESC)
    else $error("escape while idle mishandled");

  // A plain byte while idle is passed straight through.
  a_plain_pass: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_timeout && in_byte != B_ESC && phase_r == PH_IDLE |=>
      out_valid_r && kind_r == K_PLAIN && byte_r == $past(in_byte))
    else $error("plain byte not passed through");

endmodule

`default_nettype wire
